// File: hw/rtl/dls_pkg.sv
// Shared types, character codes and parse step functions for the
// location string splitter. No dependencies.
package dls_pkg;

	localparam int DLS_MAX_LEN = 1024;
	localparam int CHAR_W      = 16;
	localparam int FIELD_W     = 11;
	localparam int STATUS_W    = 3;
	localparam int FMT_W       = 2;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam int PFX_LEN_SHORT = 7;
	localparam int PFX_LEN_LONG  = 8;
	localparam int PFX_DIGIT_POS = 4;

	localparam logic REG_FORMAT = 1'b0;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [FIELD_W-1:0] field_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NOT_FORMAT = 3'd1,
		ST_BAD        = 3'd2,
		ST_NO_PORT    = 3'd3,
		ST_TOO_LONG   = 3'd4
	} status_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_LEGACY = 2'd0,
		FMT_INET   = 2'd1,
		FMT_INET4  = 2'd2,
		FMT_INET6  = 2'd3
	} fmt_t;

	typedef enum logic [3:0] {
		PH_PFX,
		PH_HOST0,
		PH_NHOST,
		PH_BHOST,
		PH_BAFTER,
		PH_BADPEND,
		PH_PORTPRE,
		PH_PORT,
		PH_SEP,
		PH_PATH,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t  phase;
		status_t status;
		logic    cap_he;
		logic    cap_pb;
		logic    cap_pe;
		logic    cap_sep;
		logic    set_br;
	} step_t;

	localparam char_t C_LBR   = 16'h005B;
	localparam char_t C_RBR   = 16'h005D;
	localparam char_t C_COLON = 16'h003A;
	localparam char_t C_SLASH = 16'h002F;
	localparam char_t C_SPACE = 16'h0020;
	localparam char_t C_TAB   = 16'h0009;
	localparam char_t C_A_UP  = 16'h0041;
	localparam char_t C_Z_UP  = 16'h005A;
	localparam char_t C_CASE  = 16'h0020;
	localparam char_t C_I     = 16'h0069;
	localparam char_t C_N     = 16'h006E;
	localparam char_t C_E     = 16'h0065;
	localparam char_t C_T     = 16'h0074;
	localparam char_t C_FOUR  = 16'h0034;
	localparam char_t C_SIX   = 16'h0036;

	function automatic char_t fold(char_t c);
		return (c >= C_A_UP && c <= C_Z_UP) ? char_t'(c + C_CASE) : c;
	endfunction

	// prefix check at one position; the long prefix takes either digit
	function automatic logic pfx_match(char_t c, logic [2:0] idx, logic long_pfx);
		char_t f;
		logic  m;
		f = fold(c);
		case (idx)
			3'd0: m = (f == C_I);
			3'd1: m = (f == C_N);
			3'd2: m = (f == C_E);
			3'd3: m = (f == C_T);
			3'd4: m = long_pfx ? (f == C_FOUR || f == C_SIX) : (f == C_COLON);
			3'd5: m = long_pfx ? (f == C_COLON) : (f == C_SLASH);
			default: m = (f == C_SLASH);
		endcase
		return m;
	endfunction

	// legacy: port marker '/', separator ':'; prefixed: the other way round
	function automatic step_t trk_step(phase_t ph, status_t st, char_t c, logic legacy,
			logic near_start, logic pfx_ok, logic pfx_last);
		step_t r;
		logic  is_sp;
		logic  is_sep;
		logic  is_mark;
		r.phase   = ph;
		r.status  = st;
		r.cap_he  = 1'b0;
		r.cap_pb  = 1'b0;
		r.cap_pe  = 1'b0;
		r.cap_sep = 1'b0;
		r.set_br  = 1'b0;
		is_sp   = (c == C_SPACE) || (c == C_TAB);
		is_sep  = legacy ? (c == C_COLON) : (c == C_SLASH);
		is_mark = legacy ? (c == C_SLASH) : (c == C_COLON);
		unique case (ph)
			PH_PFX: begin
				if (!pfx_ok) begin
					r.phase  = PH_DONE;
					r.status = ST_NOT_FORMAT;
				end else if (pfx_last) begin
					r.phase = PH_HOST0;
				end
			end
			PH_HOST0, PH_NHOST: begin
				if (ph == PH_HOST0 && c == C_LBR) begin
					r.phase  = PH_BHOST;
					r.set_br = 1'b1;
				end else if (is_sep) begin
					r.cap_he  = 1'b1;
					r.cap_sep = 1'b1;
					if (legacy && near_start) begin
						r.phase  = PH_DONE;
						r.status = ST_NOT_FORMAT;
					end else begin
						r.phase = PH_SEP;
					end
				end else if (is_mark) begin
					r.cap_he = 1'b1;
					r.phase  = PH_PORTPRE;
				end else begin
					r.phase = PH_NHOST;
				end
			end
			PH_BHOST: begin
				if (c == C_RBR) begin
					r.cap_he = 1'b1;
					r.phase  = PH_BAFTER;
				end else if (!legacy && c == C_SLASH) begin
					r.phase  = PH_DONE;
					r.status = ST_BAD;
				end
			end
			PH_BAFTER: begin
				if (is_sep) begin
					r.cap_sep = 1'b1;
					r.phase   = PH_SEP;
				end else if (is_mark) begin
					r.phase = PH_PORTPRE;
				end else if (!is_sp) begin
					if (legacy) begin
						r.phase = PH_BADPEND;
					end else begin
						r.phase  = PH_DONE;
						r.status = ST_BAD;
					end
				end
			end
			PH_BADPEND: begin
				if (is_sep) begin
					r.phase  = PH_DONE;
					r.status = ST_BAD;
				end
			end
			PH_PORTPRE: begin
				if (is_sep) begin
					r.phase  = PH_DONE;
					r.status = ST_NO_PORT;
				end else if (!is_sp) begin
					r.cap_pb = 1'b1;
					r.cap_pe = 1'b1;
					r.phase  = PH_PORT;
				end
			end
			PH_PORT: begin
				if (is_sep) begin
					r.cap_sep = 1'b1;
					r.phase   = PH_SEP;
				end else if (!is_sp) begin
					r.cap_pe = 1'b1;
				end
			end
			PH_SEP:  r.phase = PH_PATH;
			PH_PATH: r.phase = PH_PATH;
			PH_DONE: r.phase = PH_DONE;
			default: r.phase = ph;
		endcase
		return r;
	endfunction

	function automatic status_t trk_end(phase_t ph, status_t st, logic legacy);
		status_t r;
		case (ph)
			PH_PATH: r = ST_OK;
			PH_DONE: r = st;
			PH_PFX:  r = ST_NOT_FORMAT;
			default: r = legacy ? ST_NOT_FORMAT : ST_BAD;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/dls_if.sv
// Stream interfaces of the location string splitter: character input
// and result output. Depends on dls_pkg.
interface dls_char_if import dls_pkg::*; ;
	logic  valid;
	logic  ready;
	char_t ch;
	logic  last;
	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
endinterface

interface dls_res_if import dls_pkg::*; ;
	logic    valid;
	logic    ready;
	status_t status;
	field_t  host_begin;
	field_t  host_end;
	field_t  port_begin;
	field_t  port_end;
	field_t  path_begin;
	field_t  total_length;
	modport source (output valid, status, host_begin, host_end, port_begin, port_end,
		path_begin, total_length, input ready);
	modport sink (input valid, status, host_begin, host_end, port_begin, port_end,
		path_begin, total_length, output ready);
endinterface

// File: hw/rtl/db_location_string_splitter.sv
// Location string splitter top level: input register, three parse trackers
// (legacy, short prefix, long prefix), result register and APB register.
// Depends on dls_pkg and dls_if.
// Throughput: one character per cycle unless result back-pressure stalls.
// The result register loads when a last character leaves the input register.
// Reset (arst_n low, asynchronous): empty string, no result, format_select 0.
module db_location_string_splitter import dls_pkg::*; #(
	parameter int MAX_LEN = DLS_MAX_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	dls_char_if.sink          chars,
	dls_res_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int PW      = $clog2(MAX_LEN + 1);
	localparam int NUM_TRK = 3;
	localparam int TRK_LEG = 0;
	localparam int TRK_SHT = 1;
	localparam int TRK_LNG = 2;

	typedef logic [PW-1:0] pos_t;

	localparam phase_t PH_INIT [NUM_TRK] = '{PH_HOST0, PH_PFX, PH_PFX};
	localparam int     HB_BASE [NUM_TRK] = '{0, PFX_LEN_SHORT, PFX_LEN_LONG};

	fmt_t  format_q;

	logic  valid_s1;
	char_t ch_s1;
	logic  last_s1;
	logic  adv;
	logic  store;

	pos_t  count_q;
	logic  ovf_q;
	pos_t  n_next;
	logic  ovf_d;
	logic  near_start;
	logic  is6_q;
	logic  is6_n;

	phase_t  phase_q [NUM_TRK];
	status_t st_q    [NUM_TRK];
	logic    br_q    [NUM_TRK];
	logic    port_q  [NUM_TRK];
	pos_t    he_q    [NUM_TRK];
	pos_t    pb_q    [NUM_TRK];
	pos_t    pe_q    [NUM_TRK];
	pos_t    path_q  [NUM_TRK];

	step_t   stp     [NUM_TRK];
	phase_t  ph_n    [NUM_TRK];
	status_t st_n    [NUM_TRK];
	logic    br_n    [NUM_TRK];
	logic    port_n  [NUM_TRK];
	pos_t    he_n    [NUM_TRK];
	pos_t    pb_n    [NUM_TRK];
	pos_t    pe_n    [NUM_TRK];
	pos_t    path_n  [NUM_TRK];

	logic [1:0] sel;
	status_t    fin_st;
	logic       wrong_digit;
	pos_t       hb_r;
	pos_t       he_r;
	pos_t       pb_r;
	pos_t       pe_r;
	pos_t       path_r;

	logic    res_valid_q;
	status_t status_q;
	field_t  host_begin_q;
	field_t  host_end_q;
	field_t  port_begin_q;
	field_t  port_end_q;
	field_t  path_begin_q;
	field_t  total_length_q;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_LEGACY;
		end else if (psel && penable && pwrite && paddr[APB_AW-1] == REG_FORMAT) begin
			format_q <= fmt_t'(pwdata[FMT_W-1:0]);
		end
	end

	always_comb begin
		unique case (paddr[APB_AW-1])
			REG_FORMAT: prdata = APB_DW'(format_q);
			default:    prdata = '0;
		endcase
	end

	// input register
	assign adv          = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign chars.ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	// tracker update
	assign store      = (count_q != pos_t'(MAX_LEN));
	assign n_next     = store ? pos_t'(count_q + pos_t'(1)) : count_q;
	assign ovf_d      = ovf_q || !store;
	assign near_start = (count_q < pos_t'(2));
	assign is6_n      = (store && phase_q[TRK_LNG] == PH_PFX &&
		count_q == pos_t'(PFX_DIGIT_POS)) ? (ch_s1 == C_SIX) : is6_q;

	always_comb begin
		for (int t = 0; t < NUM_TRK; t++) begin
			stp[t] = trk_step(phase_q[t], st_q[t], ch_s1, t == TRK_LEG, near_start,
				pfx_match(ch_s1, count_q[2:0], t == TRK_LNG),
				count_q == pos_t'(HB_BASE[t] - 1));
			if (store) begin
				ph_n[t]   = stp[t].phase;
				st_n[t]   = stp[t].status;
				br_n[t]   = br_q[t] | stp[t].set_br;
				port_n[t] = port_q[t] | stp[t].cap_pb;
				he_n[t]   = stp[t].cap_he ? count_q : he_q[t];
				pb_n[t]   = stp[t].cap_pb ? count_q : pb_q[t];
				pe_n[t]   = stp[t].cap_pe ? pos_t'(count_q + pos_t'(1)) : pe_q[t];
				path_n[t] = stp[t].cap_sep ? pos_t'(count_q + pos_t'(1)) : path_q[t];
			end else begin
				ph_n[t]   = phase_q[t];
				st_n[t]   = st_q[t];
				br_n[t]   = br_q[t];
				port_n[t] = port_q[t];
				he_n[t]   = he_q[t];
				pb_n[t]   = pb_q[t];
				pe_n[t]   = pe_q[t];
				path_n[t] = path_q[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			for (int t = 0; t < NUM_TRK; t++) begin
				phase_q[t] <= PH_INIT[t];
				st_q[t]    <= ST_OK;
				br_q[t]    <= 1'b0;
				port_q[t]  <= 1'b0;
			end
		end else if (adv) begin
			if (last_s1) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				for (int t = 0; t < NUM_TRK; t++) begin
					phase_q[t] <= PH_INIT[t];
					st_q[t]    <= ST_OK;
					br_q[t]    <= 1'b0;
					port_q[t]  <= 1'b0;
				end
			end else begin
				count_q <= n_next;
				ovf_q   <= ovf_d;
				for (int t = 0; t < NUM_TRK; t++) begin
					phase_q[t] <= ph_n[t];
					st_q[t]    <= st_n[t];
					br_q[t]    <= br_n[t];
					port_q[t]  <= port_n[t];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is6_q <= is6_n;
			for (int t = 0; t < NUM_TRK; t++) begin
				he_q[t]   <= he_n[t];
				pb_q[t]   <= pb_n[t];
				pe_q[t]   <= pe_n[t];
				path_q[t] <= path_n[t];
			end
		end
	end

	// result selection
	always_comb begin
		unique case (format_q)
			FMT_LEGACY: sel = 2'(TRK_LEG);
			FMT_INET:   sel = 2'(TRK_SHT);
			default:    sel = 2'(TRK_LNG);
		endcase
	end

	assign wrong_digit = (format_q == FMT_INET4 && is6_n) || (format_q == FMT_INET6 && !is6_n);

	always_comb begin
		if (ovf_d) begin
			fin_st = ST_TOO_LONG;
		end else if (wrong_digit) begin
			fin_st = ST_NOT_FORMAT;
		end else begin
			fin_st = trk_end(ph_n[sel], st_n[sel], sel == 2'(TRK_LEG));
		end
		if (fin_st == ST_OK) begin
			hb_r   = pos_t'(HB_BASE[sel]) + pos_t'(br_n[sel]);
			he_r   = he_n[sel];
			pb_r   = port_n[sel] ? pb_n[sel] : n_next;
			pe_r   = port_n[sel] ? pe_n[sel] : n_next;
			path_r = path_n[sel];
		end else begin
			hb_r   = '0;
			he_r   = '0;
			pb_r   = '0;
			pe_r   = '0;
			path_r = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_q       <= fin_st;
			host_begin_q   <= FIELD_W'(hb_r);
			host_end_q     <= FIELD_W'(he_r);
			port_begin_q   <= FIELD_W'(pb_r);
			port_end_q     <= FIELD_W'(pe_r);
			path_begin_q   <= FIELD_W'(path_r);
			total_length_q <= FIELD_W'(n_next);
		end
	end

	assign result.valid        = res_valid_q;
	assign result.status       = status_q;
	assign result.host_begin   = host_begin_q;
	assign result.host_end     = host_end_q;
	assign result.port_begin   = port_begin_q;
	assign result.port_end     = port_end_q;
	assign result.path_begin   = path_begin_q;
	assign result.total_length = total_length_q;

endmodule

// File: hw/rtl/dls_checker.sv
// Port-level checks for the location string splitter, bound to the top level.
// Depends on dls_pkg and db_location_string_splitter.
module dls_checker import dls_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         res_valid,
	input logic         res_ready,
	input logic [2:0]   res_status,
	input field_t       host_begin,
	input field_t       host_end,
	input field_t       port_begin,
	input field_t       port_end,
	input field_t       path_begin,
	input field_t       total_length,
	input logic         pready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) &&
		$stable(path_begin) && $stable(total_length))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status <= ST_TOO_LONG)
		else $error("status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_OK |-> host_begin == '0 && host_end == '0 &&
		port_begin == '0 && port_end == '0 && path_begin == '0)
		else $error("field positions set on failed parse");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind db_location_string_splitter dls_checker u_dls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_status   (result.status),
	.host_begin   (result.host_begin),
	.host_end     (result.host_end),
	.port_begin   (result.port_begin),
	.port_end     (result.port_end),
	.path_begin   (result.path_begin),
	.total_length (result.total_length),
	.pready       (pready)
);

// File: tb/tb_db_location_string_splitter.sv
// Self-checking testbench for db_location_string_splitter: streams location strings
// in all four formats, predicts the host/port/path split in SV and checks each result.
// Depends on dls_pkg, dls_if and the splitter RTL.
module tb_db_location_string_splitter;
	import dls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 200;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_CHARS    = 36;
	localparam logic [APB_AW-1:0] FMT_ADDR = APB_AW'(4 * REG_FORMAT);

	typedef struct packed {
		logic  fin;
		char_t ch;
	} char_item_t;

	typedef struct packed {
		status_t status;
		field_t  host_begin;
		field_t  host_end;
		field_t  port_begin;
		field_t  port_end;
		field_t  path_begin;
		field_t  total_length;
	} loc_fields_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	char_t             in_ch = '0;
	logic              in_last = 1'b0;
	logic              out_ready = 1'b0;
	logic              apb_sel = 1'b0;
	logic              apb_en = 1'b0;
	logic              apb_wr = 1'b0;
	logic [APB_AW-1:0] apb_addr = FMT_ADDR;
	logic [APB_DW-1:0] apb_wdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	dls_char_if char_bus ();
	dls_res_if  res_bus ();

	assign char_bus.valid = in_valid;
	assign char_bus.ch    = in_ch;
	assign char_bus.last  = in_last;
	assign res_bus.ready  = out_ready;

	db_location_string_splitter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_bus),
		.result  (res_bus),
		.psel    (apb_sel),
		.penable (apb_en),
		.pwrite  (apb_wr),
		.paddr   (apb_addr),
		.pwdata  (apb_wdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// predictor state
	char_t       loc_buf [DLS_MAX_LEN];
	int          loc_len = 0;
	bit          loc_over = 1'b0;
	fmt_t        cur_fmt = FMT_LEGACY;
	int          host_b, host_e, port_b, port_e, path_b;
	loc_fields_t pending_splits[$];

	// stimulus and bookkeeping
	char_item_t char_q[$];
	char_t      scratch[$];
	bit         item_busy = 1'b0;
	int         gap_left = 0;
	int         stall_left = 0;
	int         hold_left = 0;
	int         queued_chars = 0;
	int         chars_sent = 0;
	int         results_seen = 0;
	int         fmt_writes = 0;
	int         errors = 0;
	int         idle_cycles = 0;
	logic [15:0] cyc = '0;
	logic        quiet;
	string       name_chars = "abcdefghijklmnopqrstuvwxyz0123456789.-_";

	assign quiet = &cyc[9:8];

	always @(posedge clk) cyc <= cyc + 16'd1;

	function automatic bit is_blank(char_t c);
		return c == C_SPACE || c == C_TAB;
	endfunction

	function automatic int find_char(int from, int to, char_t c);
		while (from < to && loc_buf[from] != c) from++;
		return from;
	endfunction

	function automatic int skip_blank(int from, int to);
		while (from < to && is_blank(loc_buf[from])) from++;
		return from;
	endfunction

	function automatic int prefix_len(fmt_t f);
		return (f == FMT_INET) ? PFX_LEN_SHORT : PFX_LEN_LONG;
	endfunction

	function automatic char_t prefix_char(fmt_t f, int i);
		if (i < 4) return (i == 0) ? C_I : (i == 1) ? C_N : (i == 2) ? C_E : C_T;
		if (f == FMT_INET) return (i == 4) ? C_COLON : C_SLASH;
		if (i == 4) return (f == FMT_INET4) ? C_FOUR : C_SIX;
		return (i == 5) ? C_COLON : C_SLASH;
	endfunction

	function automatic status_t take_port(int p, int sep);
		p = skip_blank(p, sep);
		if (p >= sep) return ST_NO_PORT;
		port_b = p;
		port_e = sep;
		while (port_e > port_b && is_blank(loc_buf[port_e - 1])) port_e--;
		return ST_OK;
	endfunction

	function automatic status_t split_legacy(int n);
		int      p;
		int      sep;
		status_t st;
		if (loc_buf[0] == C_LBR) begin
			host_b = 1;
			host_e = find_char(1, n, C_RBR);
			if (host_e >= n) return ST_NOT_FORMAT;
			p = host_e + 1;
			sep = find_char(p, n, C_COLON);
			if (sep >= n) return ST_NOT_FORMAT;
			p = skip_blank(p, sep);
			if (p < sep) begin
				if (loc_buf[p] != C_SLASH) return ST_BAD;
				st = take_port(p + 1, sep);
				if (st != ST_OK) return st;
			end
		end else begin
			sep = find_char(0, n, C_COLON);
			if (sep >= n || sep == 0) return ST_NOT_FORMAT;
			host_b = 0;
			host_e = find_char(0, sep, C_SLASH);
			if (host_e < sep) begin
				st = take_port(host_e + 1, sep);
				if (st != ST_OK) return st;
			end else if (host_e == 1) begin
				return ST_NOT_FORMAT;
			end
		end
		path_b = sep + 1;
		if (path_b >= n) return ST_NOT_FORMAT;
		return ST_OK;
	endfunction

	function automatic status_t split_prefixed(int n);
		int      plen;
		int      p;
		int      sep;
		status_t st;
		char_t   c;
		plen = prefix_len(cur_fmt);
		if (n < plen) return ST_NOT_FORMAT;
		for (int i = 0; i < plen; i++) begin
			c = loc_buf[i];
			if (c >= C_A_UP && c <= C_Z_UP) c = c + C_CASE;
			if (c != prefix_char(cur_fmt, i)) return ST_NOT_FORMAT;
		end
		p = plen;
		sep = find_char(p, n, C_SLASH);
		if (sep >= n) return ST_BAD;
		if (loc_buf[p] == C_LBR) begin
			host_b = p + 1;
			host_e = find_char(host_b, n, C_RBR);
			if (host_e >= n || host_e > sep) return ST_BAD;
			p = skip_blank(host_e + 1, sep);
			if (p < sep) begin
				if (loc_buf[p] != C_COLON) return ST_BAD;
				st = take_port(p + 1, sep);
				if (st != ST_OK) return st;
			end
		end else begin
			host_b = p;
			host_e = find_char(p, sep, C_COLON);
			if (host_e < sep) begin
				st = take_port(host_e + 1, sep);
				if (st != ST_OK) return st;
			end
		end
		path_b = sep + 1;
		if (path_b >= n) return ST_BAD;
		return ST_OK;
	endfunction

	function automatic void absorb_char(char_t c, bit fin);
		status_t     st;
		loc_fields_t r;
		int          n;
		if (loc_len < DLS_MAX_LEN) begin
			loc_buf[loc_len] = c;
			loc_len++;
		end else begin
			loc_over = 1'b1;
		end
		if (!fin) return;
		n = loc_len;
		host_b = 0;
		host_e = 0;
		path_b = 0;
		port_b = n;
		port_e = n;
		if (loc_over) st = ST_TOO_LONG;
		else if (cur_fmt == FMT_LEGACY) st = split_legacy(n);
		else st = split_prefixed(n);
		if (st != ST_OK) begin
			host_b = 0;
			host_e = 0;
			port_b = 0;
			port_e = 0;
			path_b = 0;
		end
		r.status       = st;
		r.host_begin   = field_t'(host_b);
		r.host_end     = field_t'(host_e);
		r.port_begin   = field_t'(port_b);
		r.port_end     = field_t'(port_e);
		r.path_begin   = field_t'(path_b);
		r.total_length = field_t'(n);
		pending_splits.push_back(r);
		loc_len = 0;
		loc_over = 1'b0;
	endfunction

	function automatic string split_text(loc_fields_t r);
		return $sformatf("status=%0d host=[%0d,%0d) port=[%0d,%0d) path=%0d len=%0d",
			r.status, r.host_begin, r.host_end, r.port_begin, r.port_end,
			r.path_begin, r.total_length);
	endfunction

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic char_t special_char();
		case ($urandom_range(0, 5))
			0: return C_COLON;
			1: return C_SLASH;
			2: return C_LBR;
			3: return C_RBR;
			4: return C_SPACE;
			default: return C_TAB;
		endcase
	endfunction

	function automatic char_t blank_char();
		return $urandom_range(0, 1) ? C_SPACE : C_TAB;
	endfunction

	function automatic char_t text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return char_t'(name_chars[$urandom_range(0, name_chars.len() - 1)]);
		if (r < 86) return C_A_UP + char_t'($urandom_range(0, 25));
		if (r < 95) return char_t'($urandom_range(0, 65535));
		return special_char();
	endfunction

	function automatic void push_scratch();
		for (int k = 0; k < scratch.size(); k++) begin
			char_q.push_back({k == scratch.size() - 1, scratch[k]});
			queued_chars++;
		end
		scratch.delete();
	endfunction

	function automatic void push_text(string t);
		for (int k = 0; k < t.len(); k++) scratch.push_back(char_t'(t[k]));
		push_scratch();
	endfunction

	function automatic void push_noise();
		repeat ($urandom_range(1, 10))
			scratch.push_back($urandom_range(0, 1) ? special_char() : text_char());
		push_scratch();
	endfunction

	// mostly well-formed: optional prefix, host (maybe bracketed), optional port, path
	function automatic void push_random_location(fmt_t f);
		bit    legacy;
		char_t mark;
		char_t sep;
		char_t c;
		legacy = (f == FMT_LEGACY);
		mark = legacy ? C_SLASH : C_COLON;
		sep = legacy ? C_COLON : C_SLASH;
		if (!legacy) begin
			for (int k = 0; k < prefix_len(f); k++) begin
				c = prefix_char(f, k);
				if (k < 4 && $urandom_range(0, 3) == 0) c = c - C_CASE;
				scratch.push_back(c);
			end
			if ($urandom_range(0, 19) == 0)
				scratch[$urandom_range(0, scratch.size() - 1)] = text_char();
		end
		if ($urandom_range(0, 3) == 0) begin
			scratch.push_back(C_LBR);
			repeat ($urandom_range(0, 5)) scratch.push_back(text_char());
			if ($urandom_range(0, 9) != 0) scratch.push_back(C_RBR);
			repeat ($urandom_range(0, 1)) scratch.push_back(blank_char());
		end else begin
			repeat ($urandom_range(0, 6)) scratch.push_back(text_char());
		end
		if ($urandom_range(0, 1)) begin
			scratch.push_back(mark);
			repeat ($urandom_range(0, 2)) scratch.push_back(blank_char());
			repeat ($urandom_range(0, 5))
				scratch.push_back(char_t'("0") + char_t'($urandom_range(0, 9)));
			repeat ($urandom_range(0, 2)) scratch.push_back(blank_char());
		end
		if ($urandom_range(0, 19) != 0) scratch.push_back(sep);
		repeat ($urandom_range(0, 8)) scratch.push_back(text_char());
		if (scratch.size() == 0) scratch.push_back(text_char());
		push_scratch();
	endfunction

	task automatic wait_idle(int settle);
		while (char_q.size() != 0 || item_busy || pending_splits.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// write, then read back
	task automatic write_format(fmt_t f);
		@(posedge clk);
		apb_sel <= 1'b1;
		apb_en <= 1'b0;
		apb_wr <= 1'b1;
		apb_wdata <= APB_DW'(f);
		@(posedge clk);
		apb_en <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apb_wr <= 1'b0;
		apb_en <= 1'b0;
		@(posedge clk);
		apb_en <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apb_sel <= 1'b0;
		apb_en <= 1'b0;
		if (prdata !== APB_DW'(f))
			note_error($sformatf("format_select readback %0h, wrote %0d", prdata, f));
		cur_fmt = f;
		fmt_writes++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		char_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_ch <= '0;
			in_last <= 1'b0;
		end else begin
			if (in_valid && char_bus.ready) begin
				absorb_char(in_ch, in_last);
				chars_sent++;
				item_busy = 1'b0;
			end
			if (!in_valid || char_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (char_q.size() != 0) begin
					nxt = char_q.pop_front();
					item_busy = 1'b1;
					in_valid <= 1'b1;
					in_ch <= nxt.ch;
					in_last <= nxt.fin;
					gap_left = (!quiet && $urandom_range(0, 2) == 0) ? draw_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		loc_fields_t got;
		loc_fields_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (res_bus.valid && out_ready) begin
				got.status       = res_bus.status;
				got.host_begin   = res_bus.host_begin;
				got.host_end     = res_bus.host_end;
				got.port_begin   = res_bus.port_begin;
				got.port_end     = res_bus.port_end;
				got.path_begin   = res_bus.path_begin;
				got.total_length = res_bus.total_length;
				results_seen++;
				if (pending_splits.size() == 0) begin
					note_error({"unexpected result ", split_text(got)});
				end else begin
					want = pending_splits.pop_front();
					if (got.status !== want.status || got.host_begin !== want.host_begin ||
							got.host_end !== want.host_end ||
							got.port_begin !== want.port_begin ||
							got.port_end !== want.port_end ||
							got.path_begin !== want.path_begin ||
							got.total_length !== want.total_length)
						note_error({"expected ", split_text(want), " got ", split_text(got)});
				end
				if (results_seen % 20 == 0) hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left = draw_gap() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && char_bus.ready) || (res_bus.valid && out_ready) || apb_sel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		fmt_t fmt;
		int   pick;
		int   phase_start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_format(FMT_LEGACY);
		push_text("srv:db");
		push_text("srv/3050:d");
		push_text("srv/ 3050 \t:d");
		push_text("srv/ \t:d");
		push_text("[::1]:db");
		push_text("[h] / 30 :p");
		push_text("[h]x:p");
		push_text("c:\\db");
		push_text(":db");
		push_text("srv:");
		push_text("nocolon");
		push_text("[abc");
		push_text("x");
		scratch = '{16'hFFFF, 16'h0000, C_COLON, 16'hFFFF};
		push_scratch();
		repeat (DLS_MAX_LEN + 1) scratch.push_back(char_t'("a"));
		push_scratch();
		wait_idle(4);

		write_format(FMT_INET);
		push_text("inet://host:3050/db");
		push_text("INET://[::1]:3050/db");
		push_text("inet://[a/b]/db");
		push_text("inet://h: /db");
		push_text("inet://h");
		push_text("inet://h/");
		push_text("inet:/");
		push_text("inet://[h]x/p");
		wait_idle(4);

		write_format(FMT_INET4);
		push_text("Inet4://h:1/p");
		push_text("inet6://x/p");
		wait_idle(4);

		write_format(FMT_INET6);
		push_text("inet6://[::1]/db");
		push_text("inet4://[::1] : 5 /db");
		push_text("iNeT6://[::1] : 5\t/db");
		wait_idle(4);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			fmt = (ph < 4) ? fmt_t'(ph) : fmt_t'($urandom_range(0, 3));
			write_format(fmt);
			phase_start = queued_chars;
			while (queued_chars - phase_start < PHASE_CHARS) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) push_random_location(fmt);
				else if (pick < 95) push_random_location(fmt_t'($urandom_range(0, 3)));
				else push_noise();
			end
			wait_idle(4);
		end

		wait_idle(10);
		$display("Run covered %0d strings (%0d characters) over %0d format settings,",
			results_seen, chars_sent, fmt_writes);
		$display("including over-length strings and long result back-pressure.");
		if (errors == 0 && pending_splits.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d errors", errors);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/dls_pkg.sv
hw/rtl/dls_if.sv
hw/rtl/db_location_string_splitter.sv
hw/rtl/dls_checker.sv
tb/tb_db_location_string_splitter.sv
